### design/mgpe_pkg.sv
// Shared types and constants of the mono glyph pixel expander.
package mgpe_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int CMP_BITS       = 17;
    localparam int COLOR_BITS     = 16;
    localparam int BYTE_BITS      = 8;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int PIX_IDX_BITS   = 3;
    localparam logic [PIX_IDX_BITS-1:0] LAST_PIX_IDX = 3'd7;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SET_BIT_COLOR = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_INK_COLOR     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HIDE_GLYPH    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GLYPH_WIDTH   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SCREEN_HEIGHT = 3'd5;

    // Output tuser flag positions
    localparam int UFLAG_WIDTH_OVF  = 0;
    localparam int UFLAG_HEIGHT_OVF = 1;
    localparam int OUT_USER_BITS    = 2;

    typedef struct packed {
        logic [COLOR_BITS-1:0] set_bit_color;
        logic [COLOR_BITS-1:0] ink_color;
        logic                  hide_glyph;
        logic [7:0]            glyph_width;
        logic [9:0]            screen_width;
        logic [9:0]            screen_height;
    } cfg_t;

endpackage

### design/mgpe_front.sv
// Input side: accepts bitmap byte requests into a two-entry queue.
module mgpe_front
    import mgpe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [((BYTE_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                           s_axis_tuser,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [BYTE_BITS-1:0]           q_byte,
    output logic                           q_start,
    output logic [COORD_BITS-1:0]          q_origin_x,
    output logic [COORD_BITS-1:0]          q_origin_y
);

    localparam int ENTRY_BITS = BYTE_BITS + 1 + 2 * COORD_BITS;

    logic [ENTRY_BITS-1:0] fifo_mem_reg [2];
    logic                  wr_ptr_reg, wr_ptr_next;
    logic                  rd_ptr_reg, rd_ptr_next;
    logic [1:0]            count_reg, count_next;
    logic                  push, pop;
    logic [ENTRY_BITS-1:0] wr_entry, rd_entry;

    assign s_axis_tready = (count_reg != 2'd2);
    assign q_valid       = (count_reg != 2'd0);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_valid && q_ready;

    assign wr_entry = {s_axis_tdata[BYTE_BITS+2*COORD_BITS-1:BYTE_BITS+COORD_BITS],
                       s_axis_tdata[BYTE_BITS+COORD_BITS-1:BYTE_BITS],
                       s_axis_tuser,
                       s_axis_tdata[BYTE_BITS-1:0]};

    assign rd_entry   = fifo_mem_reg[rd_ptr_reg];
    assign q_byte     = rd_entry[BYTE_BITS-1:0];
    assign q_start    = rd_entry[BYTE_BITS];
    assign q_origin_x = rd_entry[BYTE_BITS+COORD_BITS:BYTE_BITS+1];
    assign q_origin_y = rd_entry[ENTRY_BITS-1:BYTE_BITS+COORD_BITS+1];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

### design/mgpe_back.sv
// Pixel side: walks the queued byte one pixel per cycle while the output is not stalled, and holds the cursor.
module mgpe_back
    import mgpe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [BYTE_BITS-1:0]           q_byte,
    input  logic                           q_start,
    input  logic [COORD_BITS-1:0]          q_origin_x,
    input  logic [COORD_BITS-1:0]          q_origin_y,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    output logic [OUT_USER_BITS-1:0]       m_axis_tuser
);

    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
    localparam int PAD_BITS      = OUT_DATA_BITS - 2 * COORD_BITS - COLOR_BITS;

    logic                    busy_reg, busy_next;
    logic [BYTE_BITS-1:0]    bits_reg, bits_next;
    logic [PIX_IDX_BITS-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS-1:0]   cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0]   cursor_y_reg, cursor_y_next;
    logic [COORD_BITS-1:0]   row_origin_reg, row_origin_next;
    logic                    stopped_reg, stopped_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]   out_x_reg;
    logic [COORD_BITS-1:0]   out_y_reg;
    logic [COLOR_BITS-1:0]   out_color_reg;
    logic                    out_last_reg;
    logic                    out_wov_reg;
    logic                    out_hov_reg;

    logic                    head_take, start, drop, work, out_free, emit;
    logic [BYTE_BITS-1:0]    cur_bits;
    logic [COORD_BITS-1:0]   cx, cy, rox, nx_c, diff;
    logic [COORD_BITS:0]     nx, ny;
    logic [PIX_IDX_BITS-1:0] idx;
    logic [COLOR_BITS-1:0]   color;
    logic                    wov, wrap, hov, last;

    always_comb
    begin
        head_take = !busy_reg && q_valid;
        start     = head_take && q_start;
        drop      = head_take && !q_start && stopped_reg;
        work      = busy_reg || (head_take && !drop);
        out_free  = !out_valid_reg || m_axis_tready;
        emit      = work && out_free;
        q_ready   = !busy_reg && (drop || out_free);

        cur_bits = busy_reg ? bits_reg : q_byte;
        cx       = start ? q_origin_x : cursor_x_reg;
        cy       = start ? q_origin_y : cursor_y_reg;
        rox      = start ? q_origin_x : row_origin_reg;
        idx      = busy_reg ? cnt_reg : '0;

        color = (cur_bits[BYTE_BITS-1] || cfg.hide_glyph) ? cfg.set_bit_color
                                                           : cfg.ink_color;
        nx    = {1'b0, cx} + {{COORD_BITS{1'b0}}, 1'b1};
        nx_c  = nx[COORD_BITS-1:0];
        wov   = CMP_BITS'(nx) >= CMP_BITS'(cfg.screen_width);
        diff  = nx_c - rox;
        wrap  = !wov && (diff == COORD_BITS'(cfg.glyph_width));
        ny    = {1'b0, cy} + {{COORD_BITS{1'b0}}, 1'b1};
        hov   = wrap && (CMP_BITS'(ny) >= CMP_BITS'(cfg.screen_height));
        last  = wov || wrap || (idx == LAST_PIX_IDX);

        busy_next       = busy_reg;
        bits_next       = bits_reg;
        cnt_next        = cnt_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        row_origin_next = row_origin_reg;
        stopped_next    = stopped_reg;
        out_valid_next  = out_valid_reg;

        if (emit)
        begin
            busy_next       = !last;
            bits_next       = {cur_bits[BYTE_BITS-2:0], 1'b0};
            cnt_next        = idx + {{(PIX_IDX_BITS-1){1'b0}}, 1'b1};
            row_origin_next = rox;
            cursor_y_next   = cy;
            out_valid_next  = 1'b1;
            if (wov)
            begin
                cursor_x_next = nx_c;
                stopped_next  = 1'b1;
            end
            else if (wrap)
            begin
                cursor_x_next = rox;
                cursor_y_next = ny[COORD_BITS-1:0];
                stopped_next  = hov;
            end
            else
            begin
                cursor_x_next = nx_c;
                stopped_next  = 1'b0;
            end
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cnt_reg        <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            row_origin_reg <= '0;
            stopped_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cnt_reg        <= cnt_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            row_origin_reg <= row_origin_next;
            stopped_reg    <= stopped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (emit)
        begin
            out_x_reg     <= cx;
            out_y_reg     <= cy;
            out_color_reg <= color;
            out_last_reg  <= last;
            out_wov_reg   <= wov;
            out_hov_reg   <= hov;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_BITS{1'b0}}, out_color_reg, out_y_reg, out_x_reg};
    assign m_axis_tlast  = out_last_reg;
    always_comb
    begin
        m_axis_tuser                   = '0;
        m_axis_tuser[UFLAG_WIDTH_OVF]  = out_wov_reg;
        m_axis_tuser[UFLAG_HEIGHT_OVF] = out_hov_reg;
    end

endmodule

### design/mono_glyph_pixel_expander.sv
// Top level of the mono glyph pixel expander: register file and the two halves.
//
// Usage:
//   s_axis carries one glyph bitmap byte per request; tuser marks the first byte
//   of a glyph, which loads the origin from tdata. m_axis carries one pixel write
//   per request: x, y and RGB565 color in tdata, tlast on the final pixel of a
//   byte, tuser flags for width and height overflow.
//   Registers are written through cfg_wr_en / cfg_addr / cfg_wdata while idle.
// Path: the first pixel of a byte passes through the input queue, then the
//   output register.
// Throughput: one pixel per cycle while m_axis_tready allows; a full byte yields
//   eight pixels, a byte ending early on a row wrap or overflow yields fewer, and
//   a byte of a stopped glyph is discarded with none. The pixel walker sets this rate.
// Reset: colors, sizes and cursor go to their defaults and the glyph is stopped,
//   so bytes without a preceding glyph start draw nothing.
// Stall: when m_axis_tready is low the output register holds its pixel, the
//   walker freezes, and the two-entry queue keeps taking requests until full.
module mono_glyph_pixel_expander
    import mgpe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [CFG_ADDR_BITS-1:0]       cfg_addr,
    input  logic [CFG_DATA_BITS-1:0]       cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: bitmap_byte, origin_x, origin_y (from bit 0 up), zero padded
    input  logic [((BYTE_BITS+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: glyph_start
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: pixel_x, pixel_y, pixel_color (from bit 0 up), zero padded
    output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // tlast: last_of_byte
    output logic                           m_axis_tlast,
    // tuser: width_overflow, height_overflow (from bit 0 up)
    output logic [OUT_USER_BITS-1:0]       m_axis_tuser
);

    cfg_t cfg_reg, cfg_next;

    logic                  q_valid;
    logic                  q_ready;
    logic [BYTE_BITS-1:0]  q_byte;
    logic                  q_start;
    logic [COORD_BITS-1:0] q_origin_x;
    logic [COORD_BITS-1:0] q_origin_y;

    // Register file: unknown indexes are dropped, values trimmed to width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SET_BIT_COLOR: cfg_next.set_bit_color = cfg_wdata;
                CFG_INK_COLOR:     cfg_next.ink_color     = cfg_wdata;
                CFG_HIDE_GLYPH:    cfg_next.hide_glyph    = cfg_wdata[0];
                CFG_GLYPH_WIDTH:   cfg_next.glyph_width   = cfg_wdata[7:0];
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_wdata[9:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_wdata[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bit_color <= 16'h0000;
            cfg_reg.ink_color     <= 16'hFFFF;
            cfg_reg.hide_glyph    <= 1'b0;
            cfg_reg.glyph_width   <= 8'd16;
            cfg_reg.screen_width  <= 10'd320;
            cfg_reg.screen_height <= 10'd240;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mgpe_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_byte        (q_byte),
        .q_start       (q_start),
        .q_origin_x    (q_origin_x),
        .q_origin_y    (q_origin_y)
    );

    mgpe_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_byte        (q_byte),
        .q_start       (q_start),
        .q_origin_x    (q_origin_x),
        .q_origin_y    (q_origin_y),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### design/mgpe_checker.sv
// Port-level checks of the mono glyph pixel expander and their bind.
module mgpe_checker
    import mgpe_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic                           m_axis_tlast,
    input logic [OUT_USER_BITS-1:0]       m_axis_tuser
);

    // A stalled pixel request stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("pixel request withdrawn while stalled");

    // Width and height overflow never come together
    a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[UFLAG_WIDTH_OVF] && m_axis_tuser[UFLAG_HEIGHT_OVF]))
        else $error("both overflow flags set");

    // An overflow ends the byte
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[UFLAG_WIDTH_OVF] || m_axis_tuser[UFLAG_HEIGHT_OVF])
        |-> m_axis_tlast)
        else $error("overflow pixel without last_of_byte");

    // Pixels of one byte follow without gaps
    a_byte_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a byte's pixels");

endmodule

bind mono_glyph_pixel_expander mgpe_checker #(
    .COORD_BITS (COORD_BITS)
) u_mgpe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
